### sv/pds_pkg.sv
// Shared types and constants for the positional deque store.
// Used by pds_ctrl, pds_dp and positional_deque_store_top.
`default_nettype none

package pds_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_READ       = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_op;
        logic dump_next;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_dump;
        logic multi;
        logic dump_end;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/pds_ctrl.sv
// Request sequencer for the positional deque store.
// Depends on pds_pkg; drives pds_dp through ctrl_cmd_t.
`default_nettype none

module pds_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire pds_pkg::dp_status_t dp_st,
    output pds_pkg::ctrl_cmd_t      dp_cmd,
    output logic                    busy
);

    pds_pkg::state_t state_reg;
    pds_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pds_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pds_pkg::S_IDLE:
            begin
                if (start && dp_st.is_dump && dp_st.multi)
                begin
                    state_next = pds_pkg::S_DUMP;
                end
            end
            pds_pkg::S_DUMP:
            begin
                if (dp_st.dump_end)
                begin
                    state_next = pds_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pds_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd = '0;
        busy   = 1'b0;
        unique case (state_reg)
            pds_pkg::S_IDLE:
            begin
                dp_cmd.load_op = start;
            end
            pds_pkg::S_DUMP:
            begin
                dp_cmd.dump_next = 1'b1;
                busy             = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    a_dump_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pds_pkg::S_DUMP && dp_st.dump_end) |=> !busy)
        else $error("dump did not return to idle");

    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !dp_cmd.load_op)
        else $error("request loaded while busy");

    a_dump_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && dp_st.is_dump && dp_st.multi) |=> busy)
        else $error("multi-entry dump did not hold off requests");

endmodule

`default_nettype wire

### sv/pds_dp.sv
// Datapath of the positional deque store: shifting cell row, length, result registers.
// Depends on pds_pkg; controlled by pds_ctrl.
`default_nettype none

module pds_dp #(
    parameter int DEPTH = pds_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pds_pkg::ctrl_cmd_t                  dp_cmd,
    output pds_pkg::dp_status_t                      dp_st,
    input  wire logic [pds_pkg::CMD_W-1:0]           cmd,
    input  wire logic signed [pds_pkg::WORD_W-1:0]   value,
    input  wire logic [pds_pkg::POS_W-1:0]           position,
    output logic                                     valid,
    output logic [pds_pkg::STATUS_W-1:0]             status,
    output logic signed [pds_pkg::WORD_W-1:0]        data_word,
    output logic [pds_pkg::LEN_W-1:0]                length,
    output logic                                     is_empty,
    output logic                                     last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [pds_pkg::WORD_W-1:0] words_reg [DEPTH];
    logic signed [pds_pkg::WORD_W-1:0] words_next [DEPTH];
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [IW-1:0]                     idx_reg;
    logic [IW-1:0]                     idx_next;

    logic                              valid_reg;
    logic                              valid_next;
    pds_pkg::status_t                  status_reg;
    pds_pkg::status_t                  status_next;
    logic signed [pds_pkg::WORD_W-1:0] data_reg;
    logic signed [pds_pkg::WORD_W-1:0] data_next;
    logic [pds_pkg::LEN_W-1:0]         length_reg;
    logic                              empty_reg;
    logic                              last_reg;
    logic                              last_next;

    logic                              full;
    logic                              empty;
    logic [pds_pkg::POS_W-1:0]         count_ext;
    logic [IW-1:0]                     rd_addr;
    logic signed [pds_pkg::WORD_W-1:0] rd_word;
    logic                              dump_end;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_ext = pds_pkg::POS_W'(count_reg);
    assign dump_end  = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        if (dp_cmd.dump_next)
        begin
            rd_addr = idx_reg;
        end
        else if (cmd == pds_pkg::CMD_REMOVE)
        begin
            rd_addr = IW'(position - pds_pkg::POS_W'(1));
        end
        else if (cmd == pds_pkg::CMD_DUMP)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = IW'(position);
        end
    end

    assign rd_word = words_reg[rd_addr];

    assign dp_st.is_dump  = (cmd == pds_pkg::CMD_DUMP);
    assign dp_st.multi    = (count_reg > CW'(1));
    assign dp_st.dump_end = dump_end;

    always_comb
    begin
        words_next  = words_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        valid_next  = 1'b0;
        status_next = pds_pkg::ST_OK;
        data_next   = '0;
        last_next   = 1'b1;

        if (dp_cmd.dump_next)
        begin
            valid_next = 1'b1;
            data_next  = rd_word;
            last_next  = dump_end;
            idx_next   = idx_reg + IW'(1);
        end
        else if (dp_cmd.load_op)
        begin
            valid_next = 1'b1;
            case (cmd)
                pds_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = pds_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (i == int'(count_reg))
                            begin
                                words_next[i] = value;
                            end
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                pds_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = pds_pkg::ST_FULL;
                    end
                    else
                    begin
                        words_next[0] = value;
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            words_next[i] = words_reg[i-1];
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                pds_pkg::CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = pds_pkg::ST_EMPTY;
                    end
                    else if (position == '0 || position > count_ext)
                    begin
                        status_next = pds_pkg::ST_RANGE;
                    end
                    else
                    begin
                        data_next = rd_word;
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if ((i + 1) >= int'(position))
                            begin
                                words_next[i] = words_reg[i+1];
                            end
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
                pds_pkg::CMD_READ:
                begin
                    if (empty)
                    begin
                        status_next = pds_pkg::ST_EMPTY;
                    end
                    else if (position >= count_ext)
                    begin
                        status_next = pds_pkg::ST_RANGE;
                    end
                    else
                    begin
                        data_next = rd_word;
                    end
                end
                pds_pkg::CMD_DUMP:
                begin
                    if (empty)
                    begin
                        status_next = pds_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next = rd_word;
                        last_next = (count_reg == CW'(1));
                        idx_next  = IW'(1);
                    end
                end
                default:
                begin
                    status_next = pds_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        if (valid_next)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            length_reg <= pds_pkg::LEN_W'(count_next);
            empty_reg  <= (count_next == '0);
            last_reg   <= last_next;
        end
    end

    assign valid     = valid_reg;
    assign status    = status_reg;
    assign data_word = data_reg;
    assign length    = length_reg;
    assign is_empty  = empty_reg;
    assign last      = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.load_op || dp_cmd.dump_next) |=> valid_reg)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.load_op || dp_cmd.dump_next) |=> !valid_reg)
        else $error("result without request");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.dump_next |=> $stable(count_reg))
        else $error("count changed during dump");

endmodule

`default_nettype wire

### sv/positional_deque_store_top.sv
// Positional deque store: bounded ordered store with push at both ends,
// positional remove and read, and ordered dump. Uses pds_pkg, pds_ctrl, pds_dp.
//
// A request is taken when start is high and busy is low. Each result appears
// on the result ports for one cycle with valid high, in the cycle after the
// request, and the receiver cannot stall it. Push, remove, read and unknown
// commands give one result each and a new request can be taken every cycle.
// A dump of N entries gives N results on consecutive cycles (one when the
// store is empty); busy is high after the dump request while the cell row
// is read out one entry per cycle. length reports the count masked to five
// bits.
`default_nettype none

module positional_deque_store_top #(
    parameter int DEPTH = pds_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [pds_pkg::CMD_W-1:0]           cmd,
    input  wire logic signed [pds_pkg::WORD_W-1:0]   value,
    input  wire logic [pds_pkg::POS_W-1:0]           position,
    output logic                                     valid,
    output logic [pds_pkg::STATUS_W-1:0]             status,
    output logic signed [pds_pkg::WORD_W-1:0]        data_word,
    output logic [pds_pkg::LEN_W-1:0]                length,
    output logic                                     is_empty,
    output logic                                     last
);

    pds_pkg::ctrl_cmd_t  dp_cmd;
    pds_pkg::dp_status_t dp_st;

    pds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .dp_st  (dp_st),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    pds_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_st     (dp_st),
        .cmd       (cmd),
        .value     (value),
        .position  (position),
        .valid     (valid),
        .status    (status),
        .data_word (data_word),
        .length    (length),
        .is_empty  (is_empty),
        .last      (last)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for positional_deque_store_top: directed table, then random requests.
// Expected results come from a shadow deque kept in the testbench. Depends on pds_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 350;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        status_t                  st;
        logic signed [WORD_W-1:0] word;
        logic [LEN_W-1:0]         len;
        logic                     emp;
        logic                     lst;
    } deque_result_t;

    typedef struct {
        logic [CMD_W-1:0]         c;
        logic signed [WORD_W-1:0] v;
        logic [POS_W-1:0]         p;
        int                       reps;
        bit                       typed;
        deque_result_t            e;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     valid;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data_word;
    logic [LEN_W-1:0]         length;
    logic                     is_empty;
    logic                     last;

    logic signed [WORD_W-1:0] stored_words[$];
    deque_result_t            pending_results[$];
    stim_row_t                dir_rows[$];
    bit                       cur_typed;
    deque_result_t            cur_expect;
    int                       mismatches;
    int                       cycles;

    positional_deque_store_top #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .position  (position),
        .valid     (valid),
        .status    (status),
        .data_word (data_word),
        .length    (length),
        .is_empty  (is_empty),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %s: got %0h want %0h (cycle %0d)", field, got, want, cycles);
    endtask

    task automatic add_expected(input status_t s, input logic signed [WORD_W-1:0] w,
                                input logic l);
        deque_result_t r;
        r.st   = s;
        r.word = w;
        r.len  = LEN_W'(stored_words.size());
        r.emp  = (stored_words.size() == 0);
        r.lst  = l;
        pending_results.push_back(r);
    endtask

    // shadow deque: updates the stored words and queues the results of one request
    task automatic apply_request(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                                 input logic [POS_W-1:0] p);
        int cnt;
        logic signed [WORD_W-1:0] w;
        cnt = stored_words.size();
        case (c)
            CMD_PUSH_BACK:
                if (cnt >= DEPTH)
                    add_expected(ST_FULL, '0, 1'b1);
                else
                begin
                    stored_words.push_back(v);
                    add_expected(ST_OK, '0, 1'b1);
                end
            CMD_PUSH_FRONT:
                if (cnt >= DEPTH)
                    add_expected(ST_FULL, '0, 1'b1);
                else
                begin
                    stored_words.push_front(v);
                    add_expected(ST_OK, '0, 1'b1);
                end
            CMD_REMOVE:
                if (cnt == 0)
                    add_expected(ST_EMPTY, '0, 1'b1);
                else if (p == 0 || p > cnt)
                    add_expected(ST_RANGE, '0, 1'b1);
                else
                begin
                    w = stored_words[p - 1];
                    stored_words.delete(p - 1);
                    add_expected(ST_OK, w, 1'b1);
                end
            CMD_READ:
                if (cnt == 0)
                    add_expected(ST_EMPTY, '0, 1'b1);
                else if (p >= cnt)
                    add_expected(ST_RANGE, '0, 1'b1);
                else
                    add_expected(ST_OK, stored_words[p], 1'b1);
            CMD_DUMP:
                if (cnt == 0)
                    add_expected(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < cnt; i++)
                        add_expected(ST_OK, stored_words[i], i == cnt - 1);
            default:
                add_expected(ST_OK, '0, 1'b1);
        endcase
    endtask

    always @(posedge clk)
    begin
        deque_result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (valid)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", {30'd0, status}, '0);
                else
                begin
                    e = pending_results.pop_front();
                    if (status !== e.st)
                        report_mismatch("status", status, e.st);
                    if (data_word !== e.word)
                        report_mismatch("data_word", data_word, e.word);
                    if (length !== e.len)
                        report_mismatch("length", length, e.len);
                    if (is_empty !== e.emp)
                        report_mismatch("is_empty", is_empty, e.emp);
                    if (last !== e.lst)
                        report_mismatch("last", last, e.lst);
                end
            end
            if (start && !busy)
            begin
                apply_request(cmd, value, position);
                if (cur_typed)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(cur_expect);
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                                input logic [POS_W-1:0] p, input bit typed,
                                input deque_result_t e, input bit idle_ok);
        if (idle_ok)
            while ($urandom_range(99) < 23)
            begin
                start    = 1'b0;
                cmd      = CMD_W'($urandom_range(7));
                value    = $urandom;
                position = POS_W'($urandom_range(255));
                @(negedge clk);
            end
        cmd        = c;
        value      = v;
        position   = p;
        cur_typed  = typed;
        cur_expect = e;
        start      = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                           input logic [POS_W-1:0] p, input int reps, input bit typed,
                           input status_t s, input logic signed [WORD_W-1:0] w,
                           input logic [LEN_W-1:0] len, input logic emp);
        stim_row_t row;
        row.c      = c;
        row.v      = v;
        row.p      = p;
        row.reps   = reps;
        row.typed  = typed;
        row.e.st   = s;
        row.e.word = w;
        row.e.len  = len;
        row.e.emp  = emp;
        row.e.lst  = 1'b1;
        dir_rows.push_back(row);
    endtask

    initial
    begin
        int r;
        int k;
        int cnt;
        bit fill_phase;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        value      = '0;
        position   = '0;
        cur_typed  = 1'b0;
        cur_expect = '0;
        mismatches = 0;
        cycles     = 0;

        // cmd, value, position, repeats, typed, status, word, length, empty
        add_row(CMD_READ,       0,             0,   1, 1, ST_EMPTY, 0, 0,  1);
        add_row(CMD_DUMP,       0,             0,   1, 1, ST_EMPTY, 0, 0,  1);
        add_row(3'd7,           32'h1234_5678, 9,   1, 1, ST_OK,    0, 0,  1);
        add_row(CMD_PUSH_BACK,  32'h7FFF_FFFF, 0,   1, 1, ST_OK,    0, 1,  0);
        add_row(CMD_PUSH_FRONT, 32'h8000_0000, 255, 1, 1, ST_OK,    0, 2,  0);
        add_row(CMD_READ,       0,             2,   1, 1, ST_RANGE, 0, 2,  0);
        add_row(CMD_REMOVE,     0,             0,   1, 1, ST_RANGE, 0, 2,  0);
        add_row(CMD_READ,       0,             1,   1, 0, ST_OK,    0, 0,  0);
        add_row(CMD_PUSH_BACK,  32'h1000_0000, 0,   7, 0, ST_OK,    0, 0,  0);
        add_row(CMD_PUSH_FRONT, 32'hFFFF_0000, 0,   7, 0, ST_OK,    0, 0,  0);
        add_row(CMD_PUSH_BACK,  32'h5555_AAAA, 0,   1, 1, ST_FULL,  0, 16, 0);
        add_row(CMD_PUSH_FRONT, 32'hAAAA_5555, 0,   1, 1, ST_FULL,  0, 16, 0);
        add_row(CMD_READ,       0,             15,  1, 0, ST_OK,    0, 0,  0);
        add_row(CMD_DUMP,       0,             0,   1, 0, ST_OK,    0, 0,  0);
        add_row(CMD_REMOVE,     0,             16,  1, 0, ST_OK,    0, 0,  0);
        add_row(CMD_REMOVE,     0,             1,   1, 0, ST_OK,    0, 0,  0);
        add_row(CMD_REMOVE,     0,             15,  1, 1, ST_RANGE, 0, 14, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            for (int j = 0; j < dir_rows[i].reps; j++)
                send_request(dir_rows[i].c, dir_rows[i].v + j, dir_rows[i].p,
                             dir_rows[i].typed, dir_rows[i].e, 1'b1);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            fill_phase = ((n / 40) % 2) == 0;
            cnt = stored_words.size();
            r = $urandom_range(99);
            if (fill_phase)
                c = (r < 35) ? CMD_PUSH_BACK : (r < 60) ? CMD_PUSH_FRONT :
                    (r < 72) ? CMD_REMOVE : (r < 88) ? CMD_READ :
                    (r < 96) ? CMD_DUMP : CMD_W'($urandom_range(7, 5));
            else
                c = (r < 15) ? CMD_PUSH_BACK : (r < 25) ? CMD_PUSH_FRONT :
                    (r < 60) ? CMD_REMOVE : (r < 85) ? CMD_READ :
                    (r < 95) ? CMD_DUMP : CMD_W'($urandom_range(7, 5));
            k = $urandom_range(99);
            if (c == CMD_REMOVE)
                p = (k < 80) ? POS_W'($urandom_range((cnt > 0) ? cnt : 1, 1)) :
                    (k < 92) ? (($urandom_range(1)) ? POS_W'(cnt + 1) : '0) :
                    POS_W'($urandom_range(255));
            else if (c == CMD_READ)
                p = (k < 80) ? POS_W'($urandom_range((cnt > 0) ? cnt - 1 : 0, 0)) :
                    (k < 92) ? POS_W'(cnt) : POS_W'($urandom_range(255));
            else
                p = POS_W'($urandom_range(255));
            send_request(c, $urandom, p, 1'b0, '0, !(n >= 150 && n < 250));
        end

        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
